// File: rtl/exlex_pkg.sv
`default_nettype none
package exlex_pkg;

    // label store sizing
    localparam int MAX_LABEL = 32;
    localparam int IDX_W     = $clog2(MAX_LABEL);
    localparam int LEN_W     = $clog2(MAX_LABEL + 1);

    localparam logic [30:0] INT_MAX = 31'h7FFF_FFFF;

    // token codes on the output
    typedef enum logic [3:0] {
        K_INT     = 4'd0,
        K_LET     = 4'd1,
        K_NOW     = 4'd2,
        K_NOTHING = 4'd3,
        K_LABEL   = 4'd4,
        K_POWER   = 4'd5,
        K_BIND    = 4'd6,
        K_PLUS    = 4'd7,
        K_MINUS   = 4'd8,
        K_DIV     = 4'd9,
        K_MULT    = 4'd10,
        K_LPAR    = 4'd11,
        K_RPAR    = 4'd12,
        K_ERROR   = 4'd13
    } t_kind;

    // scanner mode
    typedef enum logic [4:0] {
        M_IDLE = 5'b00001,
        M_INT  = 5'b00010,
        M_WORD = 5'b00100,
        M_STAR = 5'b01000,
        M_SKIP = 5'b10000
    } t_mode;

    // word still matches the start of a keyword
    typedef struct packed {
        logic is_nothing;
        logic is_now;
        logic is_let;
    } t_kw;

    // one pending token; run means the label text is read back from the store
    typedef struct packed {
        logic        run;
        t_kind       kind;
        logic [30:0] val;
    } t_slot;

    // everything one character decides: next scanner state, store write, tokens
    typedef struct packed {
        t_mode             mode;
        logic [30:0]       accum;
        logic [LEN_W-1:0]  len;
        t_kw               kw;
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [7:0]        wr_data;
        logic [2:0]        slot_vld;
        t_slot [2:0]       slot;
    } t_plan;

    function automatic logic is_space(logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0C;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == 8'h5F;
    endfunction

endpackage
`default_nettype wire

// File: rtl/exlex_plan.sv
`default_nettype none
module exlex_plan (
    input  wire exlex_pkg::t_mode               i_mode,
    input  wire logic [30:0]                    i_accum,
    input  wire logic [exlex_pkg::LEN_W-1:0]    i_len,
    input  wire exlex_pkg::t_kw                 i_kw,
    input  wire logic [7:0]                     i_char,
    input  wire logic                           i_eos,
    output exlex_pkg::t_plan                    o_plan
);
    import exlex_pkg::*;

    t_plan       p;
    logic        take;
    logic [34:0] prod;

    function automatic logic [7:0] let_chr(logic [2:0] pos);
        case (pos)
            3'd0:    return "l";
            3'd1:    return "e";
            3'd2:    return "t";
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] now_chr(logic [2:0] pos);
        case (pos)
            3'd0:    return "n";
            3'd1:    return "o";
            3'd2:    return "w";
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] nothing_chr(logic [2:0] pos);
        case (pos)
            3'd0:    return "n";
            3'd1:    return "o";
            3'd2:    return "t";
            3'd3:    return "h";
            3'd4:    return "i";
            3'd5:    return "n";
            3'd6:    return "g";
            default: return 8'h00;
        endcase
    endfunction

    function automatic t_slot tok(t_kind k, logic [30:0] v);
        t_slot s;
        s.run  = 1'b0;
        s.kind = k;
        s.val  = v;
        return s;
    endfunction

    // a finished word: keyword token or a run of label characters
    function automatic t_slot flush_word(logic ok, t_kw kw, logic [LEN_W-1:0] len);
        t_slot s;
        s = tok(K_LABEL, '0);
        if (ok && kw.is_let && len == LEN_W'(3)) begin
            s.kind = K_LET;
        end else if (ok && kw.is_now && len == LEN_W'(3)) begin
            s.kind = K_NOW;
        end else if (ok && kw.is_nothing && len == LEN_W'(7)) begin
            s.kind = K_NOTHING;
        end else begin
            s.run = 1'b1;
        end
        return s;
    endfunction

    // accum * 10 + digit by shift and add
    assign prod = ({4'b0, i_accum} << 3) + ({4'b0, i_accum} << 1) + {31'b0, i_char[3:0]};

    always_comb begin
        p         = '0;
        p.mode    = i_mode;
        p.accum   = i_accum;
        p.len     = i_len;
        p.kw      = i_kw;
        p.wr_addr = i_len[IDX_W-1:0];
        p.wr_data = i_char;
        take      = 1'b1;

        // finish or extend what the previous characters started
        case (i_mode)
            M_SKIP: begin
                take = 1'b0;
            end
            M_INT: begin
                if (is_digit(i_char)) begin
                    p.accum = (prod > {4'b0, INT_MAX}) ? INT_MAX : prod[30:0];
                    take    = 1'b0;
                end else begin
                    p.slot_vld[0] = 1'b1;
                    p.slot[0]     = tok(K_INT, i_accum);
                    p.mode        = M_IDLE;
                end
            end
            M_WORD: begin
                if (is_alpha(i_char) || is_digit(i_char)) begin
                    if (i_len >= LEN_W'(MAX_LABEL)) begin
                        p.slot_vld[0] = 1'b1;
                        p.slot[0]     = tok(K_ERROR, '0);
                        p.mode        = M_SKIP;
                    end else begin
                        p.wr_en         = 1'b1;
                        p.len           = i_len + LEN_W'(1);
                        p.kw.is_let     = i_kw.is_let && i_len < LEN_W'(3)
                                          && i_char == let_chr(i_len[2:0]);
                        p.kw.is_now     = i_kw.is_now && i_len < LEN_W'(3)
                                          && i_char == now_chr(i_len[2:0]);
                        p.kw.is_nothing = i_kw.is_nothing && i_len < LEN_W'(7)
                                          && i_char == nothing_chr(i_len[2:0]);
                    end
                    take = 1'b0;
                end else begin
                    p.slot_vld[0] = 1'b1;
                    p.slot[0]     = flush_word(is_space(i_char) || i_char == 8'h00,
                                               i_kw, i_len);
                    p.mode        = M_IDLE;
                end
            end
            M_STAR: begin
                p.mode        = M_IDLE;
                p.slot_vld[0] = 1'b1;
                if (i_char == "*") begin
                    p.slot[0] = tok(K_POWER, '0);
                    take      = 1'b0;
                end else begin
                    p.slot[0] = tok(K_MULT, '0);
                end
            end
            default: begin
            end
        endcase

        // start a new token from this character
        if (take) begin
            if (i_char == 8'h0A) begin
                p.mode = M_SKIP;
            end else if (is_space(i_char)) begin
                p.mode = p.mode;
            end else if (is_digit(i_char)) begin
                p.accum = {27'b0, i_char[3:0]};
                p.mode  = M_INT;
            end else if (is_alpha(i_char)) begin
                p.wr_en         = 1'b1;
                p.wr_addr       = '0;
                p.len           = LEN_W'(1);
                p.kw.is_let     = i_char == "l";
                p.kw.is_now     = i_char == "n";
                p.kw.is_nothing = i_char == "n";
                p.mode          = M_WORD;
            end else if (i_char == "*") begin
                p.mode = M_STAR;
            end else begin
                p.slot_vld[1] = 1'b1;
                case (i_char)
                    "=":     p.slot[1] = tok(K_BIND, '0);
                    "+":     p.slot[1] = tok(K_PLUS, '0);
                    "-":     p.slot[1] = tok(K_MINUS, '0);
                    "/":     p.slot[1] = tok(K_DIV, '0);
                    "(":     p.slot[1] = tok(K_LPAR, '0);
                    ")":     p.slot[1] = tok(K_RPAR, '0);
                    default: begin
                        p.slot[1] = tok(K_ERROR, '0);
                        p.mode    = M_SKIP;
                    end
                endcase
            end
        end

        // end of string flushes whatever is pending
        if (i_eos) begin
            case (p.mode)
                M_INT: begin
                    p.slot_vld[2] = 1'b1;
                    p.slot[2]     = tok(K_INT, p.accum);
                end
                M_WORD: begin
                    p.slot_vld[2] = 1'b1;
                    p.slot[2]     = flush_word(1'b1, p.kw, p.len);
                end
                M_STAR: begin
                    p.slot_vld[2] = 1'b1;
                    p.slot[2]     = tok(K_MULT, '0);
                end
                default: begin
                end
            endcase
            p.mode = M_IDLE;
        end
    end

    assign o_plan = p;

endmodule
`default_nettype wire

// File: rtl/expression_lexer.sv
`default_nettype none
// Streaming lexer: one character byte per input beat, i_end_of_string on the
// last byte of a string. Each result beat carries one token; label text goes
// out as one beat per character with o_label_end on the final one, and o_last
// marks the final beat caused by an input beat.
// Input channel i_in_valid / o_in_ready, output channel o_out_valid / i_out_ready.
// o_in_ready is high while the sequencer has no token of an earlier byte left
// to hand over; a byte that makes no token leaves the sequencer idle.
// Order: a byte's tokens are held in the slot registers, then loaded into the
// output register from S_EMIT; a label run goes from S_EMIT to S_RUNW, which
// loads one character per cycle while the output is free, read from the label
// store (a synchronous-read memory).
// The output register lets a new byte be taken while the last result of the
// previous one waits; a stalled receiver holds the beat and stops the sequencer.
// Reset clears the scanner to idle and empties the output register; the label
// store needs no clearing since only written entries are read.
module expression_lexer (
    input  wire  logic        i_clk,
    input  wire  logic        i_rst_n,
    input  wire  logic        i_in_valid,
    output logic              o_in_ready,
    input  wire  logic [7:0]  i_char_in,
    input  wire  logic        i_end_of_string,
    output logic              o_out_valid,
    input  wire  logic        i_out_ready,
    output logic [3:0]        o_token_kind,
    output logic [30:0]       o_int_value,
    output logic [7:0]        o_label_char,
    output logic              o_label_end,
    output logic              o_last
);
    import exlex_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EMIT = 3'b010,
        S_RUNW = 3'b100
    } t_state;

    t_state             r_state, n_state;
    t_mode              r_mode;
    logic [30:0]        r_accum;
    logic [LEN_W-1:0]   r_len;
    t_kw                r_kw;
    logic [2:0]         r_slot_vld, n_slot_vld;
    t_slot [2:0]        r_slots;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [7:0]         r_rd_data;
    logic [7:0]         mem [MAX_LABEL];

    logic               r_o_valid;
    t_kind              r_o_kind;
    logic [30:0]        r_o_val;
    logic [7:0]         r_o_char;
    logic               r_o_lend;
    logic               r_o_last;

    t_plan              plan;
    logic               accept;
    logic               out_free;
    logic [1:0]         cur_sel;
    t_slot              cur;
    logic [2:0]         vld_rest;
    logic               more;
    logic               run_end;

    logic               load;
    t_kind              ld_kind;
    logic [30:0]        ld_val;
    logic [7:0]         ld_char;
    logic               ld_lend;
    logic               ld_last;

    // next scanner state and tokens for the offered byte
    exlex_plan u_plan (
        .i_mode  (r_mode),
        .i_accum (r_accum),
        .i_len   (r_len),
        .i_kw    (r_kw),
        .i_char  (i_char_in),
        .i_eos   (i_end_of_string),
        .o_plan  (plan)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_o_valid || i_out_ready;

    // oldest pending token
    always_comb begin
        if (r_slot_vld[0]) begin
            cur_sel = 2'd0;
        end else if (r_slot_vld[1]) begin
            cur_sel = 2'd1;
        end else begin
            cur_sel = 2'd2;
        end
        cur      = r_slots[cur_sel];
        vld_rest = r_slot_vld & ~(3'b001 << cur_sel);
        more     = |vld_rest;
        run_end  = (LEN_W'(r_idx) + LEN_W'(1)) == r_len;
    end

    // token sequencer
    always_comb begin
        n_state    = r_state;
        n_slot_vld = r_slot_vld;
        n_idx      = r_idx;
        load       = 1'b0;
        ld_kind    = cur.kind;
        ld_val     = cur.val;
        ld_char    = 8'h00;
        ld_lend    = 1'b0;
        ld_last    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_slot_vld = plan.slot_vld;
                    if (|plan.slot_vld) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (cur.run) begin
                    n_idx   = '0;
                    n_state = S_RUNW;
                end else if (out_free) begin
                    load       = 1'b1;
                    ld_last    = !more;
                    n_slot_vld = vld_rest;
                    if (!more) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_RUNW: begin
                if (out_free) begin
                    load    = 1'b1;
                    ld_kind = K_LABEL;
                    ld_val  = '0;
                    ld_char = r_rd_data;
                    ld_lend = run_end;
                    ld_last = run_end && !more;
                    if (run_end) begin
                        n_slot_vld = vld_rest;
                        n_state    = more ? S_EMIT : S_IDLE;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_mode     <= M_IDLE;
            r_accum    <= '0;
            r_len      <= '0;
            r_kw       <= '0;
            r_slot_vld <= '0;
            r_idx      <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_slot_vld <= n_slot_vld;
            r_idx      <= n_idx;
            if (accept) begin
                r_mode  <= plan.mode;
                r_accum <= plan.accum;
                r_len   <= plan.len;
                r_kw    <= plan.kw;
            end
            if (load) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // token payloads and output beat
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_slots <= plan.slot;
        end
        if (load) begin
            r_o_kind <= ld_kind;
            r_o_val  <= ld_val;
            r_o_char <= ld_char;
            r_o_lend <= ld_lend;
            r_o_last <= ld_last;
        end
    end

    // label store: written when a byte is taken, read one entry ahead of the run
    always_ff @(posedge i_clk) begin
        if (accept && plan.wr_en) begin
            mem[plan.wr_addr] <= plan.wr_data;
        end
        r_rd_data <= mem[n_idx];
    end

    assign o_out_valid  = r_o_valid;
    assign o_token_kind = r_o_kind;
    assign o_int_value  = r_o_val;
    assign o_label_char = r_o_char;
    assign o_label_end  = r_o_lend;
    assign o_last       = r_o_last;

endmodule
`default_nettype wire

// File: rtl/exlex_chk.sv
`default_nettype none
module exlex_chk (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        o_in_ready,
    input  wire logic [7:0]  i_char_in,
    input  wire logic        i_end_of_string,
    input  wire logic        o_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [3:0]  o_token_kind,
    input  wire logic [30:0] o_int_value,
    input  wire logic [7:0]  o_label_char,
    input  wire logic        o_label_end,
    input  wire logic        o_last
);
    import exlex_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_token_kind)
            && $stable(o_int_value) && $stable(o_label_char) && $stable(o_last))
        else $error("result beat changed while stalled");

    // no new byte is taken while tokens of the current one remain
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> !o_in_ready)
        else $error("input ready in the middle of a token group");

    // only label beats carry text and the end mark
    a_label: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_token_kind != K_LABEL |-> o_label_char == 8'h00 && !o_label_end)
        else $error("label text on a non-label token");

    // a group never ends inside a label run
    a_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_token_kind == K_LABEL && o_last |-> o_label_end)
        else $error("group ended inside a label run");

    // reset empties the output
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind expression_lexer exlex_chk u_exlex_chk (.*);
`default_nettype wire
